>>> rtl/oef_pkg.sv
// Shared constants and types for the one euro filter.
package oef_pkg;

  localparam int OEF_CHANNELS = 32;
  localparam int OEF_CH_W     = 5;
  localparam int OEF_DATA_W   = 32;
  localparam int OEF_RATE_W   = 12;
  localparam int OEF_CFG_W    = 16;
  localparam int OEF_CFG_IDX_W = 2;

  localparam int OEF_W_W     = 19;
  localparam int OEF_DEN_W   = 21;
  localparam int OEF_NUM_W   = 36;
  localparam int OEF_QUOT_W  = 17;
  localparam int OEF_CNT_W   = 5;

  localparam logic [19:0] OEF_TWO_PI = 20'd411775;

  localparam logic [OEF_RATE_W-1:0] OEF_RATE_RST  = 12'd60;
  localparam logic [OEF_CFG_W-1:0]  OEF_MINC_RST  = 16'd256;
  localparam logic [OEF_CFG_W-1:0]  OEF_GAIN_RST  = 16'd0;
  localparam logic [OEF_CFG_W-1:0]  OEF_DCUT_RST  = 16'd256;

  typedef enum logic [OEF_CFG_IDX_W-1:0] {
    REG_RATE = 2'd0,
    REG_MINC = 2'd1,
    REG_GAIN = 2'd2,
    REG_DCUT = 2'd3
  } oef_reg_e;

  typedef struct packed {
    logic signed [OEF_DATA_W-1:0] last_raw;
    logic signed [OEF_DATA_W-1:0] delta;
    logic signed [OEF_DATA_W-1:0] filtered;
  } oef_entry_t;

endpackage

>>> rtl/oef_mem.sv
// Per-channel state memory with a registered read port.
module oef_mem import oef_pkg::*; #(
  parameter int DEPTH = OEF_CHANNELS,
  parameter int AW    = OEF_CH_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  oef_entry_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output oef_entry_t    rdata_o
);

  oef_entry_t mem_q [DEPTH];
  oef_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/oef_div.sv
// Radix-2 restoring divider that forms the smoothing factor quotient.
module oef_div import oef_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [OEF_NUM_W-1:0]  num_i,
  input  logic [OEF_DEN_W-1:0]  den_i,
  output logic                  done_o,
  output logic [OEF_QUOT_W-1:0] quot_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [OEF_CNT_W-1:0]  cnt_q, cnt_d;
  logic [OEF_DEN_W-1:0]  rem_q, rem_d;
  logic [OEF_DEN_W-1:0]  den_q, den_d;
  logic [OEF_QUOT_W-1:0] sh_q, sh_d;
  logic [OEF_DEN_W:0]    trial;
  logic                  ge;

  assign trial = {rem_q, sh_q[OEF_QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = OEF_CNT_W'(OEF_QUOT_W);
      rem_d  = OEF_DEN_W'(num_i[OEF_NUM_W-1:OEF_QUOT_W]);
      sh_d   = num_i[OEF_QUOT_W-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? OEF_DEN_W'(trial - {1'b0, den_q}) : trial[OEF_DEN_W-1:0];
      sh_d  = {sh_q[OEF_QUOT_W-2:0], ge};
      cnt_d = cnt_q - OEF_CNT_W'(1);
      if (cnt_q == OEF_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

>>> rtl/one_euro_filter.sv
// Top level of the per-channel one euro filter: control, datapath and registers.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i/in_ready_o   channel_i, sample_i
//   output   out        out_valid_o/out_ready_i channel_out_o, filtered_o
//   config   in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A beat that hits a seen channel forms its sample smoothing factor in the 17-step
// divider; the derivative factor is cached and recomputed, with a further pass through
// the divider, after reset or a write to the rate or derivative cutoff. A first or
// out-of-range beat goes from the read state straight to the done state.
// Reset clears the seen bits and the cache at once; there is no clearing pass.
// A new beat is taken once the previous one sits in the output register.
module one_euro_filter import oef_pkg::*; #(
  parameter int CHANNELS = OEF_CHANNELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [OEF_CH_W-1:0]          channel_i,
  input  logic signed [OEF_DATA_W-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [OEF_CH_W-1:0]          channel_out_o,
  output logic signed [OEF_DATA_W-1:0] filtered_o,
  input  logic                         cfg_we_i,
  input  logic [OEF_CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [OEF_CFG_W-1:0]         cfg_wdata_i
);

  localparam int USED  = (CHANNELS < (1 << OEF_CH_W)) ? CHANNELS : (1 << OEF_CH_W);
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_READ = 11'b00000000010,
    S_BSUB = 11'b00000000100,
    S_BMUL = 11'b00000001000,
    S_BADD = 11'b00000010000,
    S_CMUL = 11'b00000100000,
    S_CUT  = 11'b00001000000,
    S_AW   = 11'b00010000000,
    S_AD   = 11'b00100000000,
    S_ADIV = 11'b01000000000,
    S_DONE = 11'b10000000000
  } oef_state_e;

  oef_state_e state_q, state_d;

  logic [OEF_RATE_W-1:0] rate_q;
  logic [OEF_CFG_W-1:0]  min_cut_q, gain_q, dcut_q;
  logic                  alpha_d_ok_q;
  logic [USED-1:0]       seen_q;
  logic                  sel_q;
  logic                  in_range_q;
  logic                  out_valid_q;

  logic [OEF_CH_W-1:0]          ch_q, ch_out_q;
  logic [IDX_W-1:0]             idx_q;
  logic signed [OEF_DATA_W-1:0] x_q, dx_q, edx_q, y_q, filt_out_q;
  logic [15:0]                  alpha_d_q, alpha_s_q, cut_q;
  logic signed [OEF_DATA_W:0]   bdiff_q;
  logic signed [53:0]           mul_q;

  logic              accept;
  logic [31:0]       ch_ext;
  logic              in_range;
  logic              out_free;
  oef_entry_t        rd_ent, wr_ent;

  logic signed [33:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [53:0] mul_p;

  logic signed [OEF_DATA_W-1:0] bl_v, bl_p;
  logic [15:0]                  bl_a;
  logic signed [54:0]           bl_acc;
  logic signed [OEF_DATA_W-1:0] bl_res;

  logic signed [OEF_DATA_W:0]   diff_raw;
  logic signed [OEF_DATA_W-1:0] diff_sat;
  logic [OEF_DATA_W:0]          mag;
  logic [32:0]                  cut_sum;
  logic [15:0]                  cut_sat;

  logic [15:0]            alpha_c;
  logic [34:0]            w_sum;
  logic [OEF_W_W-1:0]     w;
  logic [OEF_RATE_W-1:0]  rate_eff;
  logic [OEF_DEN_W-1:0]   den;
  logic [OEF_NUM_W-1:0]   num;
  logic                   div_start, div_done;
  logic [OEF_QUOT_W-1:0]  quot;
  logic [15:0]            alpha_new;

  assign ch_ext    = 32'(channel_i);
  assign in_range  = ch_ext < 32'(CHANNELS);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  oef_mem #(
    .DEPTH (USED),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_DONE) && out_free && in_range_q),
    .waddr_i (idx_q),
    .wdata_i (wr_ent),
    .re_i    (accept && in_range),
    .raddr_i (ch_ext[IDX_W-1:0]),
    .rdata_o (rd_ent)
  );

  assign wr_ent.last_raw = x_q;
  assign wr_ent.delta    = edx_q;
  assign wr_ent.filtered = y_q;

  // Saturated raw step against the stored sample.
  assign diff_raw = {x_q[OEF_DATA_W-1], x_q} - {rd_ent.last_raw[OEF_DATA_W-1], rd_ent.last_raw};
  assign diff_sat = (diff_raw[OEF_DATA_W] != diff_raw[OEF_DATA_W-1]) ?
                    (diff_raw[OEF_DATA_W] ? 32'sh80000000 : 32'sh7fffffff) :
                    diff_raw[OEF_DATA_W-1:0];

  assign mag = edx_q[OEF_DATA_W-1] ? 33'(-{edx_q[OEF_DATA_W-1], edx_q}) : {1'b0, edx_q};

  // Blend operands: derivative pass when sel_q is low, sample pass when high.
  assign bl_v = sel_q ? x_q : dx_q;
  assign bl_p = sel_q ? rd_ent.filtered : rd_ent.delta;
  assign bl_a = sel_q ? alpha_s_q : alpha_d_q;
  assign bl_acc = {{7{bl_p[OEF_DATA_W-1]}}, bl_p, 16'b0} + {mul_q[53], mul_q} + 55'sd32768;
  assign bl_res = bl_acc[47:16];

  assign cut_sum = 33'(min_cut_q) + {1'b0, mul_q[47:16]};
  assign cut_sat = (cut_sum > 33'h0FFFF) ? 16'hFFFF : cut_sum[15:0];

  assign alpha_c  = sel_q ? cut_q : dcut_q;
  assign w_sum    = mul_q[34:0] + 35'd32768;
  assign w        = w_sum[34:16];
  assign rate_eff = (rate_q == '0) ? OEF_RATE_W'(1) : rate_q;
  assign den      = {2'b0, w} + {1'b0, rate_eff, 8'b0};
  assign num      = {1'b0, w, 16'b0} + {16'b0, den[OEF_DEN_W-1:1]};
  assign div_start = (state_q == S_AD);
  assign alpha_new = quot[OEF_QUOT_W-1] ? 16'hFFFF : quot[15:0];

  oef_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Shared multiplier, one use per state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_AW: begin
        mul_a = $signed({18'b0, alpha_c});
        mul_b = $signed(OEF_TWO_PI);
      end
      S_BMUL: begin
        mul_a = {bdiff_q[OEF_DATA_W], bdiff_q};
        mul_b = $signed({4'b0, bl_a});
      end
      S_CMUL: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({4'b0, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: begin
        if (!in_range_q || !seen_q[idx_q]) begin
          state_d = S_DONE;
        end else begin
          state_d = alpha_d_ok_q ? S_BSUB : S_AW;
        end
      end
      S_BSUB: state_d = S_BMUL;
      S_BMUL: state_d = S_BADD;
      S_BADD: state_d = sel_q ? S_DONE : S_CMUL;
      S_CMUL: state_d = S_CUT;
      S_CUT:  state_d = S_AW;
      S_AW:   state_d = S_AD;
      S_AD:   state_d = S_ADIV;
      S_ADIV: if (div_done) state_d = S_BSUB;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rate_q       <= OEF_RATE_RST;
      min_cut_q    <= OEF_MINC_RST;
      gain_q       <= OEF_GAIN_RST;
      dcut_q       <= OEF_DCUT_RST;
      alpha_d_ok_q <= 1'b0;
      seen_q       <= '0;
      sel_q        <= 1'b0;
      in_range_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (oef_reg_e'(cfg_index_i))
          REG_RATE: begin
            rate_q       <= cfg_wdata_i[OEF_RATE_W-1:0];
            alpha_d_ok_q <= 1'b0;
          end
          REG_MINC: min_cut_q <= cfg_wdata_i;
          REG_GAIN: gain_q    <= cfg_wdata_i;
          REG_DCUT: begin
            dcut_q       <= cfg_wdata_i;
            alpha_d_ok_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (accept) begin
        in_range_q <= in_range;
      end
      if (state_q == S_READ) begin
        sel_q <= 1'b0;
      end
      if (state_q == S_CUT) begin
        sel_q <= 1'b1;
      end
      if (state_q == S_ADIV && div_done && !sel_q) begin
        alpha_d_ok_q <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        if (in_range_q) begin
          seen_q[idx_q] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= channel_i;
      idx_q <= ch_ext[IDX_W-1:0];
      x_q   <= sample_i;
    end
    if (state_q == S_READ) begin
      dx_q  <= diff_sat;
      y_q   <= x_q;
      edx_q <= '0;
    end
    if (state_q == S_BSUB) begin
      bdiff_q <= {bl_v[OEF_DATA_W-1], bl_v} - {bl_p[OEF_DATA_W-1], bl_p};
    end
    if (state_q == S_AW || state_q == S_BMUL || state_q == S_CMUL) begin
      mul_q <= mul_p;
    end
    if (state_q == S_BADD) begin
      if (sel_q) begin
        y_q <= bl_res;
      end else begin
        edx_q <= bl_res;
      end
    end
    if (state_q == S_CUT) begin
      cut_q <= cut_sat;
    end
    if (state_q == S_ADIV && div_done) begin
      if (sel_q) begin
        alpha_s_q <= alpha_new;
      end else begin
        alpha_d_q <= alpha_new;
      end
    end
    if (state_q == S_DONE && out_free) begin
      ch_out_q   <= ch_q;
      filt_out_q <= y_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = ch_out_q;
  assign filtered_o    = filt_out_q;

endmodule
